/* hw/rtl/rri_pkg.sv */
// ----------------------------------------------------------------------------
// rri_pkg
// Types and constants shared by the resize ratio register encoder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rri_pkg;

  // field widths of one input word and of the register images
  localparam int unsigned SIZE_IN_W  = 12;
  localparam int unsigned SIZE_DST_W = 16;
  localparam int unsigned CLIP_W     = 16;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned WORD_W     = 32;

  // ratio register holds the saturated value plus one carry bit
  localparam int unsigned RATIO_W = 33;
  localparam logic [RATIO_W-1:0] RATIO_SAT = 33'h0_FFFF_FFFF;

  // compact variant rounding: low bits and the step between levels
  localparam logic [2:0]         ROUND_MASK = 3'h7;
  localparam logic [RATIO_W-1:0] ROUND_STEP = 33'd8;

  // passband: base 64 as a shift, flat value and divide-by-zero guard
  localparam int unsigned       PB_BASE_LOG = 6;
  localparam logic [HALF_W-1:0] PB_FLAT     = 16'd64;
  localparam logic [HALF_W-1:0] PB_GUARD    = 16'hFFFF;

  // axis codes
  localparam logic AXIS_HORZ = 1'b0;
  localparam logic AXIS_VERT = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_ROUND,
    ST_PBSEL,
    ST_DIV2,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/rri_if.sv */
// ----------------------------------------------------------------------------
// rri_if
// Valid/ready channels carrying the job word in and the register images out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rri_in_if import rri_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  axis;
  logic [SIZE_IN_W-1:0]  size_in;
  logic [SIZE_DST_W-1:0] size_dst;
  logic [CLIP_W-1:0]     clip_len;

  modport source (output valid, output axis, output size_in, output size_dst,
                  output clip_len, input ready);
  modport sink   (input valid, input axis, input size_in, input size_dst,
                  input clip_len, output ready);
endinterface

interface rri_out_if import rri_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] scale_word;
  logic [WORD_W-1:0] clip_word;
  logic [WORD_W-1:0] passband_word;

  modport source (output valid, output scale_word, output clip_word,
                  output passband_word, input ready);
  modport sink   (input valid, input scale_word, input clip_word,
                  input passband_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/resize_ratio_register_encoder.sv */
// ----------------------------------------------------------------------------
// resize_ratio_register_encoder
// Scale ratio, clip and passband register images for one axis per word,
// built on one shared restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_i      in   valid/ready     axis, size_in, size_dst, clip_len
//  out_o     out  valid/ready     scale_word, clip_word, passband_word
//  cfg       in   cfg_we_i        cfg_wdata_i (compact_variant)
//
//  the shared divider, one quotient bit a cycle, is used for the ratio
//  then the passband; either divide can be skipped.
//  in_i.ready is high only while the sequencer is idle.
//  the register images double as the output register: a new word is taken
//  while a result waits, and its images are written once out_o is free.
//  reset clears the images, the variant bit and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module resize_ratio_register_encoder import rri_pkg::*; #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  rri_in_if.sink    in_i,
  rri_out_if.source out_o
);

  localparam int unsigned DvdW = SIZE_IN_W + FRAC_BITS;
  localparam int unsigned CntW = $clog2(DvdW + 1);

  state_e state_q, state_d;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DvdW-1:0]       dvd_q, dvd_d;
  logic [RATIO_W-1:0]    dvs_q, dvs_d;
  logic [RATIO_W-1:0]    rem_q, rem_d;
  logic [RATIO_W-1:0]    ratio_q, ratio_d;
  logic [HALF_W-1:0]     pb_q, pb_d;
  logic                  axis_q, axis_d;
  logic [SIZE_IN_W-1:0]  sin_q, sin_d;
  logic [SIZE_DST_W-1:0] sout_q, sout_d;
  logic [CLIP_W-1:0]     clip_q, clip_d;
  logic                  compact_q;
  logic [WORD_W-1:0]     scale_img_q, scale_img_d;
  logic [WORD_W-1:0]     clip_img_q, clip_img_d;
  logic [WORD_W-1:0]     pb_img_q, pb_img_d;
  logic                  out_valid_q, out_valid_d;

  // shared divider step: one restoring compare and subtract
  logic [RATIO_W:0]   trial;
  logic [RATIO_W:0]   diff;
  logic               fits;
  logic [DvdW-1:0]    dvd_step;
  logic [RATIO_W-1:0] rem_step;

  assign trial    = {rem_q, dvd_q[DvdW-1]};
  assign diff     = trial - {1'b0, dvs_q};
  assign fits     = (trial >= {1'b0, dvs_q});
  assign dvd_step = {dvd_q[DvdW-2:0], fits};
  assign rem_step = fits ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];

  // operand set-up for the ratio divide, straight from the input word
  logic [SIZE_IN_W-1:0] num_in;
  logic                 sout_small;

  assign num_in     = (in_i.size_in != '0) ? (in_i.size_in - SIZE_IN_W'(1)) : '0;
  assign sout_small = (in_i.size_dst < SIZE_DST_W'(2));

  // direction of the job
  logic scale_up;
  logic grow;
  logic same;

  assign scale_up = (sout_q > SIZE_DST_W'(sin_q));
  assign grow     = (sout_q >= SIZE_DST_W'(sin_q));
  assign same     = (sout_q == SIZE_DST_W'(sin_q));

  // compact variant rounding and the one-to-one override
  logic [RATIO_W-1:0] ratio_trunc;
  logic [RATIO_W-1:0] ratio_round;

  assign ratio_trunc = {ratio_q[RATIO_W-1:3], 3'b000};

  always_comb begin
    ratio_round = ratio_q;
    if (compact_q && ((ratio_q[2:0] & ROUND_MASK) != '0)) begin
      if (scale_up) begin
        ratio_round = (ratio_trunc >= ROUND_STEP) ? (ratio_trunc - ROUND_STEP) : '0;
      end else begin
        ratio_round = ratio_trunc + ROUND_STEP;
      end
    end
    if (same) begin
      ratio_round = '0;
    end
  end

  // passband gain from the mantissa range, as a shift of the dividend
  logic [RATIO_W-1:0] mant;
  logic [1:0]         k_log;
  logic [DvdW-1:0]    dvd_pb;

  assign mant = ratio_q >> FRAC_BITS;

  always_comb begin
    if (mant >= RATIO_W'(8) && mant < RATIO_W'(16)) begin
      k_log = 2'd2;
    end else if (mant >= RATIO_W'(4) && mant < RATIO_W'(8)) begin
      k_log = 2'd1;
    end else begin
      k_log = 2'd0;
    end
  end

  assign dvd_pb = DvdW'(1) << (FRAC_BITS + PB_BASE_LOG + int'(k_log));

  // handshakes
  logic in_fire;
  logic out_free;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = sout_small ? ST_ROUND : ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (cnt_q == CntW'(1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_d = ST_PBSEL;
      end
      ST_PBSEL: begin
        state_d = (grow || ratio_q == '0) ? ST_FINISH : ST_DIV2;
      end
      ST_DIV2: begin
        if (cnt_q == CntW'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and image updates
  always_comb begin
    cnt_d       = cnt_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    ratio_d     = ratio_q;
    pb_d        = pb_q;
    axis_d      = axis_q;
    sin_d       = sin_q;
    sout_d      = sout_q;
    clip_d      = clip_q;
    scale_img_d = scale_img_q;
    clip_img_d  = clip_img_q;
    pb_img_d    = pb_img_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          axis_d  = in_i.axis;
          sin_d   = in_i.size_in;
          sout_d  = in_i.size_dst;
          clip_d  = in_i.clip_len;
          dvd_d   = {num_in, {FRAC_BITS{1'b0}}};
          dvs_d   = RATIO_W'(in_i.size_dst - SIZE_DST_W'(1));
          rem_d   = '0;
          cnt_d   = CntW'(DvdW);
          ratio_d = RATIO_SAT;
        end
      end
      ST_DIV1: begin
        dvd_d = dvd_step;
        rem_d = rem_step;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          ratio_d = RATIO_W'(dvd_step);
        end
      end
      ST_ROUND: begin
        ratio_d = ratio_round;
      end
      ST_PBSEL: begin
        if (grow) begin
          pb_d = PB_FLAT;
        end else if (ratio_q == '0) begin
          pb_d = PB_GUARD;
        end else begin
          dvd_d = dvd_pb;
          dvs_d = ratio_q;
          rem_d = '0;
          cnt_d = CntW'(DvdW);
        end
      end
      ST_DIV2: begin
        dvd_d = dvd_step;
        rem_d = rem_step;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          pb_d = dvd_step[HALF_W-1:0];
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (axis_q == AXIS_VERT) begin
            scale_img_d = {ratio_q[HALF_W-1:0], scale_img_q[HALF_W-1:0]};
            clip_img_d  = {clip_q, clip_img_q[HALF_W-1:0]};
            pb_img_d    = {pb_q, pb_img_q[HALF_W-1:0]};
          end else begin
            scale_img_d = {scale_img_q[WORD_W-1:HALF_W], ratio_q[HALF_W-1:0]};
            clip_img_d  = {clip_img_q[WORD_W-1:HALF_W], clip_q};
            pb_img_d    = {pb_img_q[WORD_W-1:HALF_W], pb_q};
          end
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // control state and register images
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      compact_q   <= 1'b0;
      scale_img_q <= '0;
      clip_img_q  <= '0;
      pb_img_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      scale_img_q <= scale_img_d;
      clip_img_q  <= clip_img_d;
      pb_img_q    <= pb_img_d;
      if (cfg_we_i) begin
        compact_q <= cfg_wdata_i;
      end
    end
  end

  // divider operands and job fields
  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    ratio_q <= ratio_d;
    pb_q    <= pb_d;
    axis_q  <= axis_d;
    sin_q   <= sin_d;
    sout_q  <= sout_d;
    clip_q  <= clip_d;
  end

  // result word
  assign out_o.valid         = out_valid_q;
  assign out_o.scale_word    = scale_img_q;
  assign out_o.clip_word     = clip_img_q;
  assign out_o.passband_word = pb_img_q;

`ifndef SYNTHESIS
  // a result only appears on leaving the finish state
  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish");

  // the divider never runs with an exhausted count
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV1 || state_q == ST_DIV2) |-> cnt_q != '0)
    else $error("divider running with zero count");

  // an accepted word always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("accepted word left sequencer idle");

  // a stalled result holds the next word in finish
  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && !out_o.ready) |=>
      (state_q == ST_FINISH && out_valid_q))
    else $error("finish left while result stalled");
`endif

endmodule

`default_nettype wire
